>>> rtl/core/dtzc_pkg.sv
package dtzc_pkg;

   // width of the value that is divided
   localparam int VALUE_BITS = 32;
   // constant divisor and remainder width
   localparam int DIVISOR = 10;
   localparam int REM_BITS = 4;
   // result count width and its saturation value
   localparam int COUNT_BITS = 4;
   localparam int COUNT_MAX = 15;
   // upper bound on divisions per word
   localparam int MAX_DIVISIONS = 20;
   localparam int DIVS_BITS = $clog2(MAX_DIVISIONS + 1);
   // step counter for one bit-serial division
   localparam int STEP_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   // control from the sequencer to the divider
   typedef struct packed {
      logic start;
      logic load;
   } div_ctrl_type;

   // status from the divider back to the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_stat_type;

endpackage

>>> rtl/core/dtzc_div10.sv
module dtzc_div10
   import dtzc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [VALUE_BITS-1:0] dividend,
   output div_stat_type          stat
);

   logic [VALUE_BITS-1:0] shreg_ff, shreg_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [REM_BITS:0]     trial;
   logic                  ge;
   logic [REM_BITS:0]     diff;

   // one restoring step: bring in the next dividend bit, subtract ten if it fits
   assign trial = {rem_ff, shreg_ff[VALUE_BITS-1]};
   assign ge    = (trial >= (REM_BITS+1)'(DIVISOR));
   assign diff  = trial - (REM_BITS+1)'(DIVISOR);

   // dividend leaves at the top, quotient bits enter at the bottom
   always_comb begin
      shreg_in   = shreg_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (ctrl.start) begin
         if (ctrl.load) begin
            shreg_in = dividend;
         end
         rem_in     = '0;
         step_in    = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (VALUE_BITS > 1) begin
            shreg_in = {shreg_ff[VALUE_BITS-2:0], ge};
         end else begin
            shreg_in = VALUE_BITS'(ge);
         end
         rem_in  = ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

>>> rtl/core/decimal_trailing_zero_counter.sv
// Decimal trailing zero counter.
// Input channel: drive req_value and raise start; the word is taken at the
// rising edge where start is high and busy is low. busy stays high while a
// word is being worked on.
// Result channel: rsp_valid pulses for one cycle with rsp_zero_count and
// rsp_input_was_zero. The receiver cannot stall; the result must be taken
// in that cycle.
// A zero word returns count 0 with rsp_input_was_zero set, in the cycle
// after it is taken. Any other word runs repeated bit-serial divisions by
// ten in one shared divider, one quotient bit per cycle; each division
// runs 32 steps, then its remainder is checked. With k trailing zeros the
// result shows after k+1 divisions. The next word can be taken in the cycle
// the result shows. The divider's shift register is the rate limit.
// Reset (synchronous, active high) returns to idle and drops any word in
// progress without a result.
module decimal_trailing_zero_counter
   import dtzc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [COUNT_BITS-1:0] rsp_zero_count,
   output logic                  rsp_input_was_zero
);

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [DIVS_BITS-1:0]  divs_ff;
   logic                  rsp_valid_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_zero_ff;
   logic                  accept;
   logic [COUNT_BITS-1:0] count_inc;
   logic [DIVS_BITS-1:0]  divs_inc;
   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;

   assign accept = start && (state_ff == ST_IDLE);

   // saturating count of zero remainders, and divisions done so far
   assign count_inc = (count_ff == COUNT_BITS'(COUNT_MAX)) ? count_ff : count_ff + 1'b1;
   assign divs_inc  = divs_ff + 1'b1;

   // divider commands: load a fresh word, or divide the last quotient again
   always_comb begin
      div_ctrl.start = 1'b0;
      div_ctrl.load  = 1'b0;
      if (accept && (req_value != '0)) begin
         div_ctrl.start = 1'b1;
         div_ctrl.load  = 1'b1;
      end else if (state_ff == ST_DIVIDE && div_stat.done && div_stat.rem_zero
                   && divs_inc != DIVS_BITS'(MAX_DIVISIONS)) begin
         div_ctrl.start = 1'b1;
      end
   end

   dtzc_div10 u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (req_value),
      .stat     (div_stat)
   );

   // sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         divs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_count_ff <= '0;
         rsp_zero_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff <= '0;
                  divs_ff  <= '0;
                  if (req_value == '0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_count_ff <= '0;
                     rsp_zero_ff  <= 1'b1;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_stat.done) begin
                  divs_ff <= divs_inc;
                  if (div_stat.rem_zero) begin
                     count_ff <= count_inc;
                  end
                  // stop at the first nonzero remainder or at the division limit
                  if (!div_stat.rem_zero || divs_inc == DIVS_BITS'(MAX_DIVISIONS)) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                     rsp_count_ff <= div_stat.rem_zero ? count_inc : count_ff;
                     rsp_zero_ff  <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_zero_count     = rsp_count_ff;
   assign rsp_input_was_zero = rsp_zero_ff;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dtzc_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_WORDS  = 1450;
   localparam int QUIET_TAIL    = 200;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 40;

   // one expected result
   typedef struct packed {
      logic [COUNT_BITS-1:0] zero_count;
      logic                  input_was_zero;
   } zero_tally_type;

   // expected tallies in word order, compared as results arrive
   class zero_tally_board;
      zero_tally_type tally_queue[$];
      int unsigned failures;
      int unsigned words_taken;
      int unsigned zero_words;
      int unsigned results_seen;
      int unsigned seen_by_count[COUNT_MAX+1];

      function new();
         failures = 0;
         words_taken = 0;
         zero_words = 0;
         results_seen = 0;
         foreach (seen_by_count[i]) seen_by_count[i] = 0;
      endfunction

      // repeated division by ten until a remainder shows up or the division limit is reached
      static function zero_tally_type count_decimal_zeros(logic [VALUE_BITS-1:0] word);
         zero_tally_type res;
         logic [VALUE_BITS-1:0] quo;
         int unsigned tally;
         res.zero_count = '0;
         res.input_was_zero = 1'b0;
         if (word == '0) begin
            res.input_was_zero = 1'b1;
            return res;
         end
         quo = word;
         tally = 0;
         while ((quo % DIVISOR) == 0 && tally < MAX_DIVISIONS) begin
            quo = quo / DIVISOR;
            tally++;
         end
         if (tally > COUNT_MAX) tally = COUNT_MAX;
         res.zero_count = COUNT_BITS'(tally);
         return res;
      endfunction

      function void note_word(logic [VALUE_BITS-1:0] word);
         zero_tally_type res;
         res = count_decimal_zeros(word);
         tally_queue.push_back(res);
         words_taken++;
         if (res.input_was_zero) zero_words++;
         else seen_by_count[res.zero_count]++;
      endfunction

      function void check_result(logic [COUNT_BITS-1:0] cnt, logic was_zero);
         zero_tally_type exp;
         results_seen++;
         if (tally_queue.size() == 0) begin
            $error("unexpected result: zero_count %0d input_was_zero %0b", cnt, was_zero);
            failures++;
            return;
         end
         exp = tally_queue.pop_front();
         if (cnt !== exp.zero_count) begin
            $error("zero_count mismatch: expected %0d, actual %0d", exp.zero_count, cnt);
            failures++;
         end
         if (was_zero !== exp.input_was_zero) begin
            $error("input_was_zero mismatch: expected %0b, actual %0b",
                   exp.input_was_zero, was_zero);
            failures++;
         end
      endfunction

      function int pending();
         return tally_queue.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VALUE_BITS-1:0] req_value;
   logic                  rsp_valid;
   logic [COUNT_BITS-1:0] rsp_zero_count;
   logic                  rsp_input_was_zero;

   zero_tally_board board;
   int unsigned     cycle_count;

   decimal_trailing_zero_counter dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_zero_count     (rsp_zero_count),
      .rsp_input_was_zero (rsp_input_was_zero)
   );

   // clock
   always #CLOCK_HALF clock = ~clock;

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_zero_count, rsp_input_was_zero);
   end

   // offer one word, optionally after an idle burst, and wait until it is taken
   task automatic send_word(logic [VALUE_BITS-1:0] word, bit allow_idle);
      if (allow_idle && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start <= 1'b1;
      req_value <= word;
      do @(posedge clock); while (busy);
      board.note_word(word);
   endtask

   // hold off new words until every result is back
   task automatic drain_results();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // multiples of powers of ten, plus zeros, small and full-range words
   function automatic logic [VALUE_BITS-1:0] pick_word();
      int unsigned sel;
      int unsigned k;
      longint unsigned scale;
      longint unsigned top;
      sel = $urandom_range(0, 99);
      if (sel < 4) return '0;
      if (sel < 50) begin
         k = $urandom_range(1, 9);
         scale = 1;
         repeat (k) scale = scale * 10;
         top = 64'hFFFF_FFFF / scale;
         return VALUE_BITS'(longint'($urandom_range(1, int'(top))) * scale);
      end
      if (sel < 60) return VALUE_BITS'($urandom_range(1, 1000));
      return VALUE_BITS'($urandom);
   endfunction

   // stimulus
   initial begin
      logic [VALUE_BITS-1:0] directed_words[$];
      int unsigned deepest;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      cycle_count = 0;
      board = new();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edges of the range, zero, every count from zero to nine
      directed_words = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd5, 32'd2,
                         32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                         32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000,
                         32'd4000000000, 32'd4294967290, 32'd4294967200, 32'd0,
                         32'd20, 32'd25, 32'd3000000000, 32'd1024, 32'd0};
      foreach (directed_words[i]) send_word(directed_words[i], 1'b0);
      drain_results();

      // random words, with a full drain partway through
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2) drain_results();
         send_word(pick_word(), n < RANDOM_WORDS - QUIET_TAIL);
      end
      start <= 1'b0;

      // wait out the last results
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      deepest = 0;
      foreach (board.seen_by_count[i]) if (board.seen_by_count[i] != 0) deepest = i;
      $display("%0d words taken, %0d results checked, %0d zero words",
               board.words_taken, board.results_seen, board.zero_words);
      $display("trailing zero counts reached up to %0d, with idle bursts and a full drain",
               deepest);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/dtzc_pkg.sv
rtl/core/dtzc_div10.sv
rtl/core/decimal_trailing_zero_counter.sv
verif/tb_top.sv
